// ===== rtl/scc_pkg.sv =====
// Shared types and constants for the strongly connected components block.
package scc_pkg;

  localparam int NODES_DEF = 16;
  localparam int ROW_W     = 16;
  localparam int ROOT_W    = 4;
  localparam int MEMBER_W  = 5;
  localparam int TOTAL_W   = 4;
  localparam int NC_W      = 5;
  localparam int SN_W      = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_NODE = 1'b1;
  localparam logic [NC_W-1:0]      NC_RESET       = 5'd16;

  typedef enum logic [3:0] {
    S_LOAD,
    S_P1_FIRST,
    S_P1_WALK,
    S_P1_SCAN,
    S_P2_INIT,
    S_P2_SCAN,
    S_P2_WALK,
    S_EMIT_INIT,
    S_EMIT_SCAN,
    S_OUT_WAIT
  } state_t;

  typedef enum logic [1:0] {
    SRC_START,
    SRC_IDX,
    SRC_FIN
  } start_src_t;

  typedef struct packed {
    logic       rows_open;
    logic       p1_init;
    logic       p2_init;
    logic       emit_init;
    logic       start;
    start_src_t src;
    logic       step;
    logic       use_trans;
    logic       record;
    logic       save;
    logic       idx_inc;
    logic       k_dec;
    logic       out_hit;
    logic       out_none;
  } cmd_t;

  typedef struct packed {
    logic graph_done;
    logic walk_done;
    logic idx_done;
    logic idx_visited;
    logic k_zero;
    logic fin_visited;
    logic total_zero;
    logic emit_hit;
    logic out_taken;
    logic out_last;
  } stat_t;

endpackage

// ===== rtl/scc_ctrl.sv =====
// Sequencer for loading, both depth-first passes and result emission.
module scc_ctrl import scc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_LOAD:      if (stat.graph_done) state_next = S_P1_FIRST;
      S_P1_FIRST:  state_next = S_P1_WALK;
      S_P1_WALK:   if (stat.walk_done) state_next = S_P1_SCAN;
      S_P1_SCAN: begin
        if (stat.idx_done) state_next = S_P2_INIT;
        else if (!stat.idx_visited) state_next = S_P1_WALK;
      end
      S_P2_INIT:   state_next = S_P2_SCAN;
      S_P2_SCAN: begin
        if (stat.k_zero) state_next = S_EMIT_INIT;
        else if (!stat.fin_visited) state_next = S_P2_WALK;
      end
      S_P2_WALK:   if (stat.walk_done) state_next = S_P2_SCAN;
      S_EMIT_INIT: state_next = stat.total_zero ? S_OUT_WAIT : S_EMIT_SCAN;
      S_EMIT_SCAN: begin
        if (stat.idx_done) state_next = S_LOAD;
        else if (stat.emit_hit) state_next = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (stat.out_taken) state_next = stat.out_last ? S_LOAD : S_EMIT_SCAN;
      end
      default:     state_next = S_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.src = SRC_START;
    case (state)
      S_LOAD:     cmd.rows_open = 1'b1;
      S_P1_FIRST: begin
        cmd.p1_init = 1'b1;
        cmd.start   = 1'b1;
        cmd.src     = SRC_START;
      end
      S_P1_WALK: begin
        cmd.step   = 1'b1;
        cmd.record = 1'b1;
      end
      S_P1_SCAN: begin
        if (!stat.idx_done) begin
          cmd.idx_inc = 1'b1;
          cmd.start   = !stat.idx_visited;
          cmd.src     = SRC_IDX;
        end
      end
      S_P2_INIT:  cmd.p2_init = 1'b1;
      S_P2_SCAN: begin
        if (!stat.k_zero) begin
          cmd.k_dec = 1'b1;
          cmd.start = !stat.fin_visited;
          cmd.src   = SRC_FIN;
        end
      end
      S_P2_WALK: begin
        cmd.step      = 1'b1;
        cmd.use_trans = 1'b1;
        cmd.save      = stat.walk_done;
      end
      S_EMIT_INIT: begin
        cmd.emit_init = 1'b1;
        cmd.out_none  = stat.total_zero;
      end
      S_EMIT_SCAN: begin
        if (!stat.idx_done) begin
          cmd.idx_inc = 1'b1;
          cmd.out_hit = stat.emit_hit;
        end
      end
      S_OUT_WAIT: ;
      default:    ;
    endcase
  end

endmodule

// ===== rtl/scc_dp.sv =====
// Graph storage, walk stack, finish list, component counts and output register.
module scc_dp import scc_pkg::*; #(
  parameter int NODES = NODES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output stat_t                stat,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [ROW_W-1:0]     s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [15:0]          m_tdata,
  output logic                 m_tuser,
  output logic                 m_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int NW = $clog2(NODES);
  localparam int CW = $clog2(NODES + 1);

  logic [NC_W-1:0] node_count;
  logic [SN_W-1:0] start_node;

  logic [NODES-1:0] adj   [NODES];
  logic [NODES-1:0] trans [NODES];
  logic [NW-1:0]    stk   [NODES];
  logic [NW-1:0]    fin   [NODES];
  logic [CW-1:0]    cnt   [NODES];
  logic [NODES-1:0] vis;
  logic [NODES-1:0] rootmask;
  logic [CW-1:0]    rows_loaded, depth, size, fcount, k, idx, total, emitted;
  logic [NW-1:0]    root;

  logic [CW-1:0]    n;
  logic [NODES-1:0] live, rv, g, cand;
  logic [NODES+ROW_W-1:0] row_ext;
  logic [NW-1:0]    row, top, v, snode, fnode, node, iw;
  logic [CW-1:0]    depth_m1, k_m1;
  logic             accept, found;

  logic [ROOT_W-1:0]   o_root;
  logic [MEMBER_W-1:0] o_member;
  logic [TOTAL_W-1:0]  o_total;
  logic [31:0]         root_x, cnt_x, total_x;

  always_comb begin
    if (node_count == '0) n = CW'(1);
    else if (32'(node_count) > NODES) n = CW'(NODES);
    else n = CW'(node_count);
  end

  always_comb begin
    for (int j = 0; j < NODES; j++) live[j] = (j < 32'(n));
  end

  assign cfg_ready = 1'b1;
  assign s_tready  = cmd.rows_open;
  assign accept    = s_tvalid && s_tready;
  assign row_ext   = {{NODES{1'b0}}, s_tdata};
  assign rv        = row_ext[NODES-1:0];
  assign row       = rows_loaded[NW-1:0];

  assign depth_m1 = depth - CW'(1);
  assign top      = stk[depth_m1[NW-1:0]];
  assign g        = cmd.use_trans ? trans[top] : adj[top];
  assign cand     = g & live & ~vis;
  assign found    = |cand;

  always_comb begin
    v = '0;
    for (int j = NODES - 1; j >= 0; j--) if (cand[j]) v = NW'(j);
  end

  assign snode = (32'(start_node) < 32'(n)) ? NW'(start_node) : '0;
  assign k_m1  = k - CW'(1);
  assign fnode = fin[k_m1[NW-1:0]];
  assign iw    = idx[NW-1:0];

  always_comb begin
    case (cmd.src)
      SRC_START: node = snode;
      SRC_IDX:   node = iw;
      SRC_FIN:   node = fnode;
      default:   node = snode;
    endcase
  end

  assign stat.graph_done  = accept && ((rows_loaded + CW'(1)) >= n);
  assign stat.walk_done   = !found && (depth == CW'(1));
  assign stat.idx_done    = (idx >= n);
  assign stat.idx_visited = vis[iw];
  assign stat.k_zero      = (k == '0);
  assign stat.fin_visited = vis[fnode];
  assign stat.total_zero  = (total == '0);
  assign stat.emit_hit    = rootmask[iw] && (cnt[iw] > CW'(1));
  assign stat.out_taken   = m_tvalid && m_tready;
  assign stat.out_last    = m_tlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NC_RESET;
      start_node <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NODE_COUNT: node_count <= cfg_data;
        CFG_START_NODE: start_node <= cfg_data[SN_W-1:0];
        default:        node_count <= node_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_loaded <= '0;
    end else if (accept) begin
      rows_loaded <= stat.graph_done ? '0 : rows_loaded + CW'(1);
    end
  end

  // store the row and its column in the transpose, diagonal dropped
  always_ff @(posedge clk) begin
    if (accept) begin
      adj[row] <= rv & ~(NODES'(1) << row);
      for (int j = 0; j < NODES; j++) trans[j][row] <= rv[j] && (NW'(j) != row);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vis      <= '0;
      rootmask <= '0;
      depth    <= '0;
      fcount   <= '0;
      k        <= '0;
      idx      <= '0;
      total    <= '0;
      emitted  <= '0;
    end else begin
      // the first start of pass one replaces the whole visited mask
      if (cmd.p1_init) begin
        fcount <= '0;
        idx    <= '0;
      end
      if (cmd.p2_init) begin
        vis      <= '0;
        k        <= fcount;
        rootmask <= '0;
        total    <= '0;
      end
      if (cmd.emit_init) begin
        idx     <= '0;
        emitted <= '0;
      end
      if (cmd.idx_inc) idx <= idx + CW'(1);
      if (cmd.k_dec) k <= k_m1;
      if (cmd.start) begin
        if (!cmd.p1_init) vis[node] <= 1'b1;
        else vis <= NODES'(1) << node;
        depth <= CW'(1);
      end
      if (cmd.step) begin
        if (found) begin
          vis[v] <= 1'b1;
          depth  <= depth + CW'(1);
        end else begin
          depth <= depth_m1;
          if (cmd.record) fcount <= fcount + CW'(1);
        end
      end
      if (cmd.save) begin
        rootmask[root] <= 1'b1;
        if (size > CW'(1)) total <= total + CW'(1);
      end
      if (cmd.out_hit) emitted <= emitted + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      stk[0] <= node;
      root   <= node;
      size   <= CW'(1);
    end
    if (cmd.step) begin
      if (found) begin
        stk[depth[NW-1:0]] <= v;
        size <= size + CW'(1);
      end else if (cmd.record) begin
        fin[fcount[NW-1:0]] <= top;
      end
    end
    if (cmd.save) cnt[root] <= size;
  end

  assign root_x  = 32'(iw);
  assign cnt_x   = 32'(cnt[iw]);
  assign total_x = 32'(total);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_hit || cmd.out_none) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_none) begin
      o_root   <= '0;
      o_member <= '0;
      o_total  <= '0;
      m_tuser  <= 1'b0;
      m_tlast  <= 1'b1;
    end else if (cmd.out_hit) begin
      o_root   <= root_x[ROOT_W-1:0];
      o_member <= cnt_x[MEMBER_W-1:0];
      o_total  <= total_x[TOTAL_W-1:0];
      m_tuser  <= 1'b1;
      m_tlast  <= ((emitted + CW'(1)) == total);
    end
  end

  assign m_tdata = {3'b000, o_total, o_member, o_root};

endmodule

// ===== rtl/strongly_connected_components.sv =====
// Top level: strongly connected components of a small directed graph.
//
// Input stream s_*: one adjacency row per beat, row 0 first; bit j set is an
// edge to node j. A beat is taken only while the block is loading rows.
// After the row that completes node_count rows, the block walks the graph twice
// (depth-first, then on the transpose in reverse finish order).
// Output stream m_*: one beat per component of more than one node, in
// increasing root index; tlast marks the final beat. tuser low means no such
// component exists and the single beat carries zeros. Each beat waits in the
// output register until taken; a stall holds the scan and no new rows are
// taken until the last beat of the run has gone.
// Configuration: cfg_index 0 is node_count, 1 is start_node; always ready.
// Reset (synchronous rst) clears the row count and output valid and restores
// node_count to 16 and start_node to 0.
module strongly_connected_components import scc_pkg::*; #(
  parameter int NODES = NODES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [ROW_W-1:0]     s_tdata,   // adjacency_row
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [15:0]          m_tdata,   // root_node, member_count, component_total
  output logic                 m_tuser,   // found
  output logic                 m_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  scc_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  scc_dp #(.NODES(NODES)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

// ===== verif/scc_checker.sv =====
// Checker for the component finder: mirrors configuration, predicts and compares result beats.
module scc_checker import scc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [ROW_W-1:0]     s_tdata,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [15:0]          m_tdata,
  input  logic                 m_tuser,
  input  logic                 m_tlast,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output int                   errors,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N = NODES_DEF;

  typedef struct {
    logic [ROOT_W-1:0]   root;
    logic [MEMBER_W-1:0] members;
    logic [TOTAL_W-1:0]  total;
    logic                found;
    logic                last;
  } component_t;

  component_t          components_due[$];
  logic [NC_W-1:0]     node_count_q;
  logic [SN_W-1:0]     start_node_q;
  logic [ROW_W-1:0]    rows[N];
  logic [ROW_W-1:0]    rows_t[N];
  logic [N-1:0]        seen;
  int                  finish_seq[N];
  int                  finished;
  int                  root_of[N];
  int                  rows_in;

  // Depth-first walk from one node, lowest unvisited neighbour first.
  function automatic void walk_from(int s, bit transposed, bit record, logic [N-1:0] live);
    int stk[N];
    int depth;
    int u;
    int v;
    logic [N-1:0] cand;
    seen[s] = 1'b1;
    root_of[s] = s;
    depth = 1;
    stk[0] = s;
    while (depth > 0) begin
      u = stk[depth-1];
      cand = (transposed ? rows_t[u] : rows[u]) & live & ~seen;
      if (cand != '0) begin
        v = 0;
        while (!cand[v]) v++;
        seen[v] = 1'b1;
        root_of[v] = s;
        stk[depth] = v;
        depth++;
      end else begin
        depth--;
        if (record) begin
          finish_seq[finished] = u;
          finished++;
        end
      end
    end
  endfunction

  function automatic void predict_components(int n);
    logic [N-1:0] live;
    int cnt[N];
    int total;
    int emitted;
    int s;
    component_t c;
    live = (n >= N) ? '1 : ((N'(1) << n) - 1);
    s = (int'(start_node_q) < n) ? int'(start_node_q) : 0;
    seen = '0;
    finished = 0;
    walk_from(s, 1'b0, 1'b1, live);
    for (int i = 0; i < n; i++)
      if (!seen[i]) walk_from(i, 1'b0, 1'b1, live);
    for (int i = 0; i < N; i++) rows_t[i] = '0;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        if (i != j && rows[i][j]) rows_t[j][i] = 1'b1;
    seen = '0;
    for (int k = finished - 1; k >= 0; k--)
      if (!seen[finish_seq[k]]) walk_from(finish_seq[k], 1'b1, 1'b0, live);
    for (int i = 0; i < N; i++) cnt[i] = 0;
    for (int i = 0; i < n; i++) cnt[root_of[i]]++;
    total = 0;
    for (int i = 0; i < n; i++) if (cnt[i] > 1) total++;
    if (total == 0) begin
      c = '{root: '0, members: '0, total: '0, found: 1'b0, last: 1'b1};
      components_due.push_back(c);
    end else begin
      emitted = 0;
      for (int i = 0; i < n; i++)
        if (cnt[i] > 1) begin
          emitted++;
          c.root    = ROOT_W'(i);
          c.members = MEMBER_W'(cnt[i]);
          c.total   = TOTAL_W'(total);
          c.found   = 1'b1;
          c.last    = (emitted == total);
          components_due.push_back(c);
        end
    end
  endfunction

  always @(posedge clk) begin
    int n;
    component_t c;
    if (rst) begin
      node_count_q = NC_RESET;
      start_node_q = '0;
      rows_in = 0;
      components_due.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_NODE_COUNT) node_count_q = cfg_data;
        else if (cfg_index == CFG_START_NODE) start_node_q = cfg_data[SN_W-1:0];
      end
      if (m_tvalid && m_tready) begin
        if (components_due.size() == 0) begin
          $error("unexpected result beat: tdata=%h tuser=%b tlast=%b", m_tdata, m_tuser, m_tlast);
          errors++;
        end else begin
          c = components_due.pop_front();
          if (m_tdata[3:0] !== c.root) begin
            $error("root_node: expected %0d, got %0d", c.root, m_tdata[3:0]); errors++;
          end
          if (m_tdata[8:4] !== c.members) begin
            $error("member_count: expected %0d, got %0d", c.members, m_tdata[8:4]); errors++;
          end
          if (m_tdata[12:9] !== c.total) begin
            $error("component_total: expected %0d, got %0d", c.total, m_tdata[12:9]);
            errors++;
          end
          if (m_tdata[15:13] !== 3'b000) begin
            $error("tdata padding: expected 0, got %0d", m_tdata[15:13]); errors++;
          end
          if (m_tuser !== c.found) begin
            $error("found: expected %0d, got %0d", c.found, m_tuser); errors++;
          end
          if (m_tlast !== c.last) begin
            $error("last_result: expected %0d, got %0d", c.last, m_tlast); errors++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        n = (node_count_q == 0) ? 1 : (node_count_q > N) ? N : int'(node_count_q);
        if (rows_in >= N) rows_in = 0;
        rows[rows_in] = s_tdata & ~(ROW_W'(1) << rows_in);
        rows_in++;
        if (rows_in >= n) begin
          rows_in = 0;
          predict_components(n);
        end
      end
    end
    pending = components_due.size();
  end
endmodule

// ===== verif/testbench.sv =====
// Top of the component finder testbench: clock, reset, stimulus and verdict.
module testbench;
  import scc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 1000000;
  localparam int ITEMS = 310;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [ROW_W-1:0]     s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [15:0]          m_tdata;
  logic                 m_tuser;
  logic                 m_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  int                   errors;
  int                   pending;
  int                   cycles = 0;
  int                   rows_sent = 0;
  int                   burst_left = 0;
  int                   n_now = 16;
  int                   hold_left = 0;
  int                   holds_done = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  strongly_connected_components dut (.*);

  scc_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: ready pattern rotates through three modes (always, mostly, rarely ready);
  // twice it holds off while a beat waits and the sender offers the next rows.
  always @(posedge clk) begin
    int mode;
    mode = (cycles / 97) % 3;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (holds_done < 2 && cycles > 2000 + holds_done * 8000 &&
                 m_tvalid && s_tvalid) begin
      hold_left  <= 600;
      holds_done <= holds_done + 1;
      m_tready   <= 1'b0;
    end else if (mode == 0) m_tready <= 1'b1;
    else if (mode == 1) m_tready <= ($urandom_range(99) < 70);
    else m_tready <= ($urandom_range(99) < 25);
  end

  task automatic put_row(logic [ROW_W-1:0] row);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(0, 1) ? $urandom_range(1, 7) : 0) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= row;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    rows_sent++;
    if (burst_left == 0) s_tvalid <= 1'b0;
  endtask

  // Hold until the run's beats have all gone, then let the block settle.
  task automatic settle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_NODE_COUNT) n_now = (val == 0) ? 1 : (val > 16) ? 16 : int'(val);
  endtask

  function automatic logic [ROW_W-1:0] random_row();
    case ($urandom_range(3))
      0: return ROW_W'($urandom());
      1: return ROW_W'($urandom() & $urandom() & $urandom());
      2: return ROW_W'(1) << $urandom_range(15);
      default: return ROW_W'($urandom() & $urandom());
    endcase
  endfunction

  // Offer one graph; the next run's rows may follow while results are pending.
  task automatic graph_run(int kind);
    for (int i = 0; i < n_now; i++)
      case (kind)
        0: put_row('1);
        1: put_row('0);
        2: put_row(ROW_W'(1) << ((i + 1) % n_now));
        default: put_row(random_row());
      endcase
  endtask

  initial begin
    int nc;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Single node, zero count treated as one: no component.
    write_reg(CFG_NODE_COUNT, 5'd0);
    write_reg(CFG_START_NODE, 5'd31);
    put_row('1);
    settle();
    // Lowered count while loading: the next row completes the graph of rows 0 and 1.
    write_reg(CFG_NODE_COUNT, 5'd8);
    write_reg(CFG_START_NODE, 5'd0);
    put_row(16'h0002);
    put_row(16'h0001);
    settle();
    put_row(16'hFFFF);
    s_tvalid <= 1'b0;
    burst_left = 0;
    write_reg(CFG_NODE_COUNT, 5'd2);
    put_row(16'h0000);
    settle();
    // Start node out of range, small ring.
    write_reg(CFG_NODE_COUNT, 5'd4);
    write_reg(CFG_START_NODE, 5'd9);
    graph_run(2);
    settle();
    // Full graph with every edge, oversize count.
    write_reg(CFG_NODE_COUNT, 5'd31);
    write_reg(CFG_START_NODE, 5'd15);
    graph_run(0);
    while (rows_sent < ITEMS) begin
      // change the configuration only once nothing is in flight
      if ($urandom_range(1) == 1) begin
        settle();
        case ($urandom_range(9))
          0: nc = 16;
          1: nc = $urandom_range(0, 1) ? 0 : $urandom_range(17, 31);
          default: nc = $urandom_range(2, 8);
        endcase
        write_reg(CFG_NODE_COUNT, CFG_DAT_W'(nc));
        write_reg(CFG_START_NODE, CFG_DAT_W'($urandom_range(31)));
      end
      case ($urandom_range(9))
        0: graph_run(1);
        1: graph_run(2);
        2: graph_run(0);
        default: graph_run(3);
      endcase
    end
    settle();
    repeat (600) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
